// File: rtl/circular_deque_defines.svh
// Assertion macros used by the checker file of the deque.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Checked on every rising edge with reset released.
`define CD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cd_pkg.sv
// Shared constants, codes and types of the circular deque.
`timescale 1ns / 1ps
`default_nettype none

package cd_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W      = 6;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0]     status;
        logic [DATA_WIDTH-1:0] value;
        logic                  last;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [IDX_W-1:0]      raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// File: rtl/cd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled result keeps its word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/cd_ctrl.sv
// Command sequencer of the deque: index registers, capacity and store accesses.
`timescale 1ns / 1ps
`default_nettype none

module cd_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [cd_pkg::CMD_W-1:0]         i_cmd,
    input  wire logic signed [cd_pkg::DATA_WIDTH-1:0] i_push_value,
    input  wire logic                             i_cfg_valid,
    input  wire logic [cd_pkg::CAP_W-1:0]         i_capacity,
    input  wire logic                             i_res_ready,
    output logic                                  o_res_valid,
    output cd_pkg::t_result                       o_res,
    output cd_pkg::t_mem_req                      o_mem,
    input  wire logic [cd_pkg::DATA_WIDTH-1:0]    i_mem_rdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    localparam int IW = cd_pkg::IDX_W;

    logic                            r_state, n_state;
    logic [cd_pkg::CMD_W-1:0]        r_cmd, n_cmd;
    logic [cd_pkg::DATA_WIDTH-1:0]   r_word, n_word;
    logic [IW-1:0]                   r_head, n_head;
    logic [IW-1:0]                   r_tail, n_tail;
    logic [IW-1:0]                   r_ptr, n_ptr;
    logic [IW-1:0]                   r_cnt, n_cnt;
    logic                            r_empty, n_empty;
    logic [cd_pkg::CAP_W-1:0]        r_capacity, n_capacity;

    logic [IW-1:0] cap_m1;
    logic [IW-1:0] head_dec, head_inc, tail_dec, tail_inc, ptr_inc;
    logic          list_fin;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i,
                                              input logic [IW-1:0] top);
        return (i == top) ? '0 : IW'(i + 1'b1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i,
                                              input logic [IW-1:0] top);
        return (i == '0) ? top : IW'(i - 1'b1);
    endfunction

    // Highest slot in use: zero capacity acts as one, anything above the store as the store.
    always_comb begin
        if (r_capacity == '0) begin
            cap_m1 = '0;
        end else if ({1'b0, r_capacity} > (cd_pkg::CAP_W+1)'(cd_pkg::DEPTH)) begin
            cap_m1 = IW'(cd_pkg::DEPTH - 1);
        end else begin
            cap_m1 = IW'(r_capacity - 1'b1);
        end
    end

    assign head_dec = idx_dec(r_head, cap_m1);
    assign head_inc = idx_inc(r_head, cap_m1);
    assign tail_dec = idx_dec(r_tail, cap_m1);
    assign tail_inc = idx_inc(r_tail, cap_m1);
    assign ptr_inc  = idx_inc(r_ptr, cap_m1);
    assign list_fin = (r_ptr == r_tail) || (r_cnt == cap_m1);

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_word     = r_word;
        n_head     = r_head;
        n_tail     = r_tail;
        n_ptr      = r_ptr;
        n_cnt      = r_cnt;
        n_empty    = r_empty;
        n_capacity = r_capacity;
        o_mem       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_state)
            S_IDLE: begin
                // The store read starts with the request, so the word is ready next cycle.
                if (i_in_valid && (i_cmd <= cd_pkg::CMD_LIST)) begin
                    n_cmd   = i_cmd;
                    n_word  = $unsigned(i_push_value);
                    n_ptr   = r_head;
                    n_cnt   = '0;
                    n_state = S_EXEC;
                    o_mem.re    = 1'b1;
                    o_mem.raddr = (i_cmd == cd_pkg::CMD_POP_BACK) ? r_tail : r_head;
                end
            end
            S_EXEC: begin
                if (i_res_ready) begin
                    o_res_valid   = 1'b1;
                    o_res.status  = cd_pkg::ST_OK;
                    o_res.last    = 1'b1;
                    n_state       = S_IDLE;
                    unique case (r_cmd)
                        cd_pkg::CMD_PUSH_FRONT: begin
                            if (r_empty) begin
                                n_head      = cap_m1;
                                n_tail      = cap_m1;
                                n_empty     = 1'b0;
                                o_mem.we    = 1'b1;
                                o_mem.waddr = cap_m1;
                                o_mem.wdata = r_word;
                            end else if (head_dec == r_tail) begin
                                o_res.status = cd_pkg::ST_FULL;
                            end else begin
                                n_head      = head_dec;
                                o_mem.we    = 1'b1;
                                o_mem.waddr = head_dec;
                                o_mem.wdata = r_word;
                            end
                        end
                        cd_pkg::CMD_PUSH_BACK: begin
                            if (r_empty) begin
                                n_head      = '0;
                                n_tail      = '0;
                                n_empty     = 1'b0;
                                o_mem.we    = 1'b1;
                                o_mem.waddr = '0;
                                o_mem.wdata = r_word;
                            end else if (tail_inc == r_head) begin
                                o_res.status = cd_pkg::ST_FULL;
                            end else begin
                                n_tail      = tail_inc;
                                o_mem.we    = 1'b1;
                                o_mem.waddr = tail_inc;
                                o_mem.wdata = r_word;
                            end
                        end
                        cd_pkg::CMD_POP_FRONT: begin
                            if (r_empty) begin
                                o_res.status = cd_pkg::ST_EMPTY;
                            end else begin
                                o_res.value = i_mem_rdata;
                                if (r_head == r_tail) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b1;
                                end else begin
                                    n_head = head_inc;
                                end
                            end
                        end
                        cd_pkg::CMD_POP_BACK: begin
                            if (r_empty) begin
                                o_res.status = cd_pkg::ST_EMPTY;
                            end else begin
                                o_res.value = i_mem_rdata;
                                if (r_head == r_tail) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    n_empty = 1'b1;
                                end else begin
                                    n_tail = tail_dec;
                                end
                            end
                        end
                        cd_pkg::CMD_LIST: begin
                            if (r_empty) begin
                                o_res.status = cd_pkg::ST_EMPTY;
                            end else begin
                                o_res.value = i_mem_rdata;
                                o_res.last  = list_fin;
                                // Walk on: the next slot is read while this word leaves.
                                if (!list_fin) begin
                                    n_state     = S_EXEC;
                                    n_ptr       = ptr_inc;
                                    n_cnt       = IW'(r_cnt + 1'b1);
                                    o_mem.re    = 1'b1;
                                    o_mem.raddr = ptr_inc;
                                end
                            end
                        end
                        default: begin
                            o_res_valid = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_capacity = i_capacity;
            n_head     = '0;
            n_tail     = '0;
            n_empty    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_empty    <= 1'b1;
            r_capacity <= cd_pkg::CAP_RESET;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_empty    <= n_empty;
            r_capacity <= n_capacity;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_word <= n_word;
        r_ptr  <= n_ptr;
        r_cnt  <= n_cnt;
    end

endmodule

`default_nettype wire

// File: rtl/circular_deque.sv
// Top level of the circular deque: sequencer, word store and result register.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_ready   i_cmd, i_push_value
//  out      from block o_out_valid / i_out_ready o_status, o_out_value, o_last
//  cfg      to block   i_cfg_valid / o_cfg_ready i_capacity
//
// A push or pop is taken in the idle state, which also starts the store read,
// then modifies the store and produces the result in the execute state.
// A list reads one word after another, since the one store read port delivers
// a word per cycle while the result register is not full.
// Reset is synchronous; it empties the deque and sets the capacity to 32.
// A full result register stalls the sequencer; a new request is still taken
// while the last result waits.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [cd_pkg::CMD_W-1:0]             i_cmd,
    input  wire logic signed [cd_pkg::DATA_WIDTH-1:0] i_push_value,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [cd_pkg::STAT_W-1:0]                 o_status,
    output logic signed [cd_pkg::DATA_WIDTH-1:0]      o_out_value,
    output logic                                      o_last,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [cd_pkg::CAP_W-1:0]             i_capacity
);

    cd_pkg::t_result               res;
    cd_pkg::t_mem_req              mem_req;
    logic                          res_valid;
    logic                          res_ready;
    logic [cd_pkg::DATA_WIDTH-1:0] mem_rdata;

    logic            r_out_valid;
    cd_pkg::t_result r_res;

    assign res_ready   = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    cd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_capacity   (i_capacity),
        .i_res_ready  (res_ready),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_mem        (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    cd_ram #(
        .WIDTH (cd_pkg::DATA_WIDTH),
        .DEPTH (cd_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_res.status;
    assign o_out_value = $signed(r_res.value);
    assign o_last      = r_res.last;

endmodule

`default_nettype wire

// File: rtl/cd_checker.sv
// Port-level checks of the circular deque, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "circular_deque_defines.svh"

module cd_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_in_valid,
    input wire logic                                 o_in_ready,
    input wire logic [cd_pkg::CMD_W-1:0]             i_cmd,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_ready,
    input wire logic [cd_pkg::STAT_W-1:0]            o_status,
    input wire logic signed [cd_pkg::DATA_WIDTH-1:0] o_out_value,
    input wire logic                                 o_last
);

    logic req_seen;

    assign req_seen = i_in_valid && o_in_ready && (i_cmd <= cd_pkg::CMD_LIST);

    // A stalled result keeps its payload.
    `CD_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_value) && $stable(o_status) && $stable(o_last), "stalled result changed")

    // Failed commands carry no word and end their item.
    `CD_ASSERT(a_err_form, i_clk, i_rst_n, o_out_valid && (o_status != cd_pkg::ST_OK) |-> (o_out_value == '0) && o_last, "error result malformed")

    // Reset leaves no result on the output.
    `CD_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A valid command occupies the sequencer for the next cycle.
    `CD_ASSERT(a_busy_after_req, i_clk, i_rst_n, req_seen |=> !o_in_ready, "request taken back to back")

    // The status never takes the unused code.
    `CD_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> (o_status == cd_pkg::ST_OK) || (o_status == cd_pkg::ST_FULL) || (o_status == cd_pkg::ST_EMPTY), "unknown status code")

endmodule

bind circular_deque cd_checker u_cd_checker (.*);

`default_nettype wire

// File: dv/circular_deque_test.sv
// Self-checking testbench of the circular deque: directed and random commands against a predictor.
`timescale 1ns / 1ps

module circular_deque_test;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 8;
    // A list walks up to 32 words, one per cycle while the receiver keeps up, after its request cycle.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;

    // Command codes that the block ignores.
    localparam logic [cd_pkg::CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [cd_pkg::CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

    localparam logic [cd_pkg::CAP_W-1:0] CAP_ZERO = 6'd0;
    localparam logic [cd_pkg::CAP_W-1:0] CAP_MAX  = 6'd63;

    localparam logic [cd_pkg::DATA_WIDTH-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [cd_pkg::DATA_WIDTH-1:0] WORD_MAX = 32'h7fff_ffff;

    logic                                 i_clk        = 1'b0;
    logic                                 i_rst_n      = 1'b0;
    logic                                 i_in_valid   = 1'b0;
    logic                                 o_in_ready;
    logic [cd_pkg::CMD_W-1:0]             i_cmd        = cd_pkg::CMD_LIST;
    logic signed [cd_pkg::DATA_WIDTH-1:0] i_push_value = '0;
    logic                                 o_out_valid;
    logic                                 i_out_ready  = 1'b0;
    logic [cd_pkg::STAT_W-1:0]            o_status;
    logic signed [cd_pkg::DATA_WIDTH-1:0] o_out_value;
    logic                                 o_last;
    logic                                 i_cfg_valid  = 1'b0;
    logic                                 o_cfg_ready;
    logic [cd_pkg::CAP_W-1:0]             i_capacity   = cd_pkg::CAP_RESET;

    circular_deque u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_out_value  (o_out_value),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_capacity   (i_capacity)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Predicted deque contents and the results still owed by the block.
    logic [cd_pkg::DATA_WIDTH-1:0] deque_words [cd_pkg::DEPTH];
    int                            front_idx;
    int                            rear_idx;
    bit                            deque_empty;
    logic [cd_pkg::CAP_W-1:0]      capacity_reg;
    cd_pkg::t_result               pending_results [$];

    int failures     = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    int ready_mode   = 0;
    int ready_span   = 0;

    function automatic void clear_deque();
        front_idx   = 0;
        rear_idx    = 0;
        deque_empty = 1'b1;
    endfunction

    function automatic int effective_capacity();
        if (capacity_reg == 0) begin
            return 1;
        end
        if (capacity_reg > cd_pkg::DEPTH) begin
            return cd_pkg::DEPTH;
        end
        return int'(capacity_reg);
    endfunction

    function automatic void owe_result(input logic [cd_pkg::STAT_W-1:0] status,
                                       input logic [cd_pkg::DATA_WIDTH-1:0] value,
                                       input logic last);
        cd_pkg::t_result r;
        r.status = status;
        r.value  = value;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_deque(input logic [cd_pkg::CMD_W-1:0] cmd,
                                          input logic [cd_pkg::DATA_WIDTH-1:0] word);
        int cap;
        int nxt;
        int idx;
        int count;
        bit fin;
        cap = effective_capacity();
        if (front_idx >= cap || rear_idx >= cap) begin
            clear_deque();
        end
        case (cmd)
            cd_pkg::CMD_PUSH_FRONT: begin
                if (deque_empty) begin
                    front_idx   = cap - 1;
                    rear_idx    = cap - 1;
                    deque_empty = 1'b0;
                    deque_words[front_idx] = word;
                    owe_result(cd_pkg::ST_OK, '0, 1'b1);
                end else begin
                    nxt = (front_idx == 0) ? cap - 1 : front_idx - 1;
                    if (nxt == rear_idx) begin
                        owe_result(cd_pkg::ST_FULL, '0, 1'b1);
                    end else begin
                        front_idx = nxt;
                        deque_words[front_idx] = word;
                        owe_result(cd_pkg::ST_OK, '0, 1'b1);
                    end
                end
            end
            cd_pkg::CMD_PUSH_BACK: begin
                if (deque_empty) begin
                    front_idx   = 0;
                    rear_idx    = 0;
                    deque_empty = 1'b0;
                    deque_words[0] = word;
                    owe_result(cd_pkg::ST_OK, '0, 1'b1);
                end else begin
                    nxt = (rear_idx + 1 >= cap) ? 0 : rear_idx + 1;
                    if (nxt == front_idx) begin
                        owe_result(cd_pkg::ST_FULL, '0, 1'b1);
                    end else begin
                        rear_idx = nxt;
                        deque_words[rear_idx] = word;
                        owe_result(cd_pkg::ST_OK, '0, 1'b1);
                    end
                end
            end
            cd_pkg::CMD_POP_FRONT: begin
                if (deque_empty) begin
                    owe_result(cd_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    owe_result(cd_pkg::ST_OK, deque_words[front_idx], 1'b1);
                    if (front_idx == rear_idx) begin
                        clear_deque();
                    end else begin
                        front_idx = (front_idx + 1 >= cap) ? 0 : front_idx + 1;
                    end
                end
            end
            cd_pkg::CMD_POP_BACK: begin
                if (deque_empty) begin
                    owe_result(cd_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    owe_result(cd_pkg::ST_OK, deque_words[rear_idx], 1'b1);
                    if (front_idx == rear_idx) begin
                        clear_deque();
                    end else begin
                        rear_idx = (rear_idx == 0) ? cap - 1 : rear_idx - 1;
                    end
                end
            end
            cd_pkg::CMD_LIST: begin
                if (deque_empty) begin
                    owe_result(cd_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    idx   = front_idx;
                    count = 0;
                    fin   = 1'b0;
                    while (!fin) begin
                        fin = (idx == rear_idx) || (count + 1 >= cap);
                        owe_result(cd_pkg::ST_OK, deque_words[idx], fin);
                        count++;
                        idx = (idx + 1 >= cap) ? 0 : idx + 1;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Sends one request in bursts separated by random gaps; returns at the accepting edge.
    task automatic send_request(input logic [cd_pkg::CMD_W-1:0] cmd,
                                input logic [cd_pkg::DATA_WIDTH-1:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_push_value <= word;
        do @(posedge i_clk); while (!o_in_ready);
        predict_deque(cmd, word);
    endtask

    task automatic stop_requests();
        i_in_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_results_drained();
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [cd_pkg::CAP_W-1:0] cap);
        stop_requests();
        wait_results_drained();
        // Ignored commands leave no result behind, so give the block time to settle.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_capacity  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        capacity_reg = cap;
        clear_deque();
    endtask

    function automatic logic [cd_pkg::DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: begin
                return WORD_MIN;
            end
            1: begin
                return WORD_MAX;
            end
            2: begin
                return '0;
            end
            3: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic test_empty_and_ignored();
        send_request(cd_pkg::CMD_LIST, pick_word());
        send_request(cd_pkg::CMD_POP_FRONT, pick_word());
        send_request(cd_pkg::CMD_POP_BACK, pick_word());
        send_request(CMD_RESERVED_LO, WORD_MAX);
        send_request(CMD_RESERVED_HI, WORD_MIN);
    endtask

    task automatic test_both_ends();
        send_request(cd_pkg::CMD_PUSH_FRONT, WORD_MAX);
        send_request(cd_pkg::CMD_PUSH_BACK, WORD_MIN);
        send_request(cd_pkg::CMD_PUSH_FRONT, '0);
        send_request(cd_pkg::CMD_PUSH_BACK, '1);
        send_request(cd_pkg::CMD_LIST, '0);
        send_request(cd_pkg::CMD_POP_FRONT, '0);
        send_request(cd_pkg::CMD_POP_BACK, '0);
        send_request(cd_pkg::CMD_POP_BACK, '0);
        send_request(cd_pkg::CMD_POP_FRONT, '0);
        send_request(cd_pkg::CMD_POP_FRONT, '0);
    endtask

    // With the word at slot 0, a pop from the rear moves the tail to the top slot.
    task automatic test_rear_wrap();
        write_capacity(6'd4);
        send_request(cd_pkg::CMD_PUSH_BACK, 32'h1234_5678);
        send_request(cd_pkg::CMD_PUSH_FRONT, 32'h9abc_def0);
        send_request(cd_pkg::CMD_POP_BACK, '0);
        send_request(cd_pkg::CMD_LIST, '0);
        send_request(cd_pkg::CMD_POP_BACK, '0);
    endtask

    task automatic test_single_slot();
        write_capacity(6'd1);
        send_request(cd_pkg::CMD_PUSH_BACK, 32'h0f0f_0f0f);
        send_request(cd_pkg::CMD_PUSH_FRONT, 32'hf0f0_f0f0);
        send_request(cd_pkg::CMD_PUSH_BACK, 32'h5555_aaaa);
        send_request(cd_pkg::CMD_LIST, '0);
        send_request(cd_pkg::CMD_POP_BACK, '0);
        send_request(cd_pkg::CMD_PUSH_FRONT, 32'hdead_beef);
        send_request(cd_pkg::CMD_POP_FRONT, '0);
    endtask

    // Random traffic that leans toward filling, draining or neither, so both full and empty are hit.
    task automatic run_random_phase(input logic [cd_pkg::CAP_W-1:0] cap, input int count);
        int issued;
        int lean;
        int lean_left;
        int pick;
        int push_pct;
        bit paused;
        logic [cd_pkg::CMD_W-1:0] cmd;
        issued    = 0;
        lean      = 0;
        lean_left = 0;
        paused    = 1'b0;
        write_capacity(cap);
        while (issued < count) begin
            if (lean_left == 0) begin
                lean      = $urandom_range(0, 2);
                lean_left = $urandom_range(4, 40);
            end
            lean_left--;
            push_pct = (lean == 0) ? 80 : (lean == 1) ? 20 : 50;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                cmd = cd_pkg::CMD_W'($urandom_range(CMD_RESERVED_HI, CMD_RESERVED_LO));
            end else if (pick < 13) begin
                cmd = cd_pkg::CMD_LIST;
            end else if ($urandom_range(0, 99) < push_pct) begin
                cmd = $urandom_range(0, 1) ? cd_pkg::CMD_PUSH_FRONT : cd_pkg::CMD_PUSH_BACK;
            end else begin
                cmd = $urandom_range(0, 1) ? cd_pkg::CMD_POP_FRONT : cd_pkg::CMD_POP_BACK;
            end
            send_request(cmd, pick_word());
            if (cmd <= cd_pkg::CMD_LIST) begin
                issued++;
            end
            if (!paused && issued >= count / 2) begin
                paused = 1'b1;
                stop_requests();
                wait_results_drained();
            end
        end
    endtask

    // The receiver switches between always ready, light, heavy and random stalling.
    always @(posedge i_clk) begin
        if (ready_span == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_span <= $urandom_range(4, 60);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            0: begin
                i_out_ready <= 1'b1;
            end
            1: begin
                i_out_ready <= $urandom_range(0, 1);
            end
            2: begin
                i_out_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                i_out_ready <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    always @(posedge i_clk) begin
        cd_pkg::t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d, out_value %h, last %b",
                       o_status, o_out_value, o_last);
                failures++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    failures++;
                end
                if (o_out_value !== exp_r.value) begin
                    $error("out_value: expected %h, got %h", exp_r.value, o_out_value);
                    failures++;
                end
                if (o_last !== exp_r.last) begin
                    $error("last: expected %b, got %b", exp_r.last, o_last);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("circular_deque_test NOT OK");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < cd_pkg::DEPTH; i++) begin
            deque_words[i] = '0;
        end
        capacity_reg = cd_pkg::CAP_RESET;
        clear_deque();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_ignored();
        test_both_ends();
        test_rear_wrap();
        test_single_slot();
        run_random_phase(CAP_ZERO, 20);
        run_random_phase(CAP_MAX, 60);
        run_random_phase(6'd1, 20);
        run_random_phase(6'd7, 50);
        run_random_phase(6'd2, 20);
        run_random_phase(6'd19, 60);
        run_random_phase(cd_pkg::CAP_RESET, 70);

        stop_requests();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("circular_deque_test OK");
        end else begin
            $display("circular_deque_test NOT OK");
        end
        $finish;
    end

endmodule
